// File: rtl/assert_macros.svh
// Assertion macros shared by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Overlapping implication, checked outside reset.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/rnlp_pkg.sv
// Package with types, constants and the digit decoder of the literal parser.
`timescale 1ns / 1ps
`default_nettype none

package rnlp_pkg;

  // Accumulator width and fixed field widths.
  localparam int WordBits  = 32;
  localparam int ValueBits = 32;
  localparam int RadixBits = 5;
  localparam int CharBits  = 8;

  // Character codes that steer the parser.
  localparam logic [CharBits-1:0] ChHash  = 8'h23;
  localparam logic [CharBits-1:0] ChPoint = 8'h2E;
  localparam logic [CharBits-1:0] ChZero  = 8'h30;
  localparam logic [CharBits-1:0] ChNine  = 8'h39;
  localparam logic [CharBits-1:0] ChUpA   = 8'h41;
  localparam logic [CharBits-1:0] ChUpF   = 8'h46;
  localparam logic [CharBits-1:0] ChLoA   = 8'h61;
  localparam logic [CharBits-1:0] ChLoF   = 8'h66;
  localparam logic [CharBits-1:0] ChLoX   = 8'h78;
  localparam logic [CharBits-1:0] ChUpX   = 8'h58;
  localparam logic [CharBits-1:0] ChLoT   = 8'h74;
  localparam logic [CharBits-1:0] ChUpT   = 8'h54;
  localparam logic [CharBits-1:0] ChLoO   = 8'h6F;
  localparam logic [CharBits-1:0] ChUpO   = 8'h4F;

  // Number bases and the "not a digit" code.
  localparam logic [RadixBits-1:0] BaseNone = 5'd0;
  localparam logic [RadixBits-1:0] BaseOct  = 5'd8;
  localparam logic [RadixBits-1:0] BaseDec  = 5'd10;
  localparam logic [RadixBits-1:0] BaseHex  = 5'd16;
  localparam logic [RadixBits-1:0] NoDigit  = 5'd16;

  // Parser phase, one-hot.
  typedef enum logic [3:0] {
    PhIdle   = 4'b0001,
    PhHash   = 4'b0010,
    PhZero   = 4'b0100,
    PhDigits = 4'b1000
  } phase_e;

  // Architectural parser state.
  typedef struct packed {
    phase_e                 phase;
    logic [RadixBits-1:0]   base;
    logic [WordBits-1:0]    acc;
    logic                   point;
  } state_t;

  // One input character transaction.
  typedef struct packed {
    logic [CharBits-1:0] ch;
    logic                start_req;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic [ValueBits-1:0] value;
    logic                 is_number;
    logic                 saw_point;
  } result_t;

  // Hex digit value of a character, or NoDigit.
  function automatic logic [RadixBits-1:0] digit_of(input logic [CharBits-1:0] c);
    logic [RadixBits-1:0] d;
    d = NoDigit;
    if (c >= ChZero && c <= ChNine) begin
      d = RadixBits'(c - ChZero);
    end else if (c >= ChUpA && c <= ChUpF) begin
      d = RadixBits'(c - ChUpA) + BaseDec;
    end else if (c >= ChLoA && c <= ChLoF) begin
      d = RadixBits'(c - ChLoA) + BaseDec;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// File: rtl/rnlp_in_if.sv
// Character channel: valid/ready handshake with one character and a start flag.
`timescale 1ns / 1ps
`default_nettype none

interface rnlp_in_if;
  import rnlp_pkg::*;

  logic                valid;
  logic                ready;
  logic [CharBits-1:0] ch;
  logic                start_req;

  modport source (output valid, output ch, output start_req, input ready);
  modport sink   (input valid, input ch, input start_req, output ready);
endinterface

`default_nettype wire

// File: rtl/rnlp_out_if.sv
// Result channel: valid/ready handshake with the parsed literal.
`timescale 1ns / 1ps
`default_nettype none

interface rnlp_out_if;
  import rnlp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ValueBits-1:0] value;
  logic                 is_number;
  logic                 saw_point;

  modport source (output valid, output value, output is_number, output saw_point,
                  input ready);
  modport sink   (input valid, input value, input is_number, input saw_point,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/rnlp_in_stage.sv
// Input register that captures one character transaction per cycle when free.
`timescale 1ns / 1ps
`default_nettype none

module rnlp_in_stage
  import rnlp_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  rnlp_in_if.sink     in_i,
  input  wire logic   take_i,
  output logic        valid_o,
  output item_t       item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  // The register accepts when empty or when its item moves on this cycle.
  assign in_i.ready = !valid_q || take_i;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= '{ch: in_i.ch, start_req: in_i.start_req};
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// File: rtl/rnlp_step.sv
// Next-state and result logic for one character of the literal.
`timescale 1ns / 1ps
`default_nettype none

module rnlp_step
  import rnlp_pkg::*;
(
  input  wire item_t                item_i,
  input  wire logic [RadixBits-1:0] default_radix_i,
  input  wire state_t               state_i,
  output state_t                    state_o,
  output logic                      emit_o,
  output result_t                   result_o
);

  logic [RadixBits-1:0] digit;
  logic [RadixBits-1:0] start_base;
  logic [WordBits-1:0]  prod;
  logic                 do_first;
  logic                 do_digit;
  state_t               nxt;

  assign digit      = digit_of(item_i.ch);
  assign start_base = (default_radix_i > BaseHex) ? BaseHex : default_radix_i;

  always_comb begin
    nxt      = state_i;
    emit_o   = 1'b0;
    result_o = '0;
    do_first = 1'b0;
    do_digit = 1'b0;
    prod     = '0;

    // Start of a literal or advance of the one in progress.
    if (item_i.start_req) begin
      nxt.base  = start_base;
      nxt.acc   = '0;
      nxt.point = 1'b0;
      if (item_i.ch == ChHash) begin
        nxt.base  = BaseHex;
        nxt.phase = PhHash;
      end else begin
        do_first = 1'b1;
      end
    end else begin
      unique case (state_i.phase)
        PhHash: begin
          do_first = 1'b1;
        end
        PhZero: begin
          nxt.phase = PhDigits;
          case (item_i.ch) inside
            ChLoX, ChUpX: nxt.base = BaseHex;
            ChLoT, ChUpT: nxt.base = BaseDec;
            ChLoO, ChUpO: nxt.base = BaseOct;
            default: begin
              if (nxt.base == BaseNone) begin
                nxt.base = BaseOct;
              end
              do_digit = 1'b1;
            end
          endcase
        end
        PhDigits: begin
          do_digit = 1'b1;
        end
        default: begin
          nxt.phase = PhIdle;
        end
      endcase
    end

    // First character of the literal proper.
    if (do_first) begin
      if (digit == NoDigit) begin
        emit_o    = 1'b1;
        nxt.phase = PhIdle;
      end else begin
        nxt.acc   = '0;
        nxt.point = 1'b0;
        if (item_i.ch == ChZero) begin
          nxt.phase = PhZero;
        end else begin
          if (nxt.base == BaseNone) begin
            nxt.base = BaseDec;
          end
          nxt.phase = PhDigits;
          do_digit  = 1'b1;
        end
      end
    end

    // Digit accumulation, point flag, or end of the literal.
    if (do_digit) begin
      if (digit < nxt.base) begin
        prod    = nxt.acc * WordBits'(nxt.base);
        nxt.acc = prod + WordBits'(digit);
      end else if (item_i.ch == ChPoint) begin
        nxt.point = 1'b1;
      end else begin
        emit_o             = 1'b1;
        result_o.value     = ValueBits'(nxt.acc);
        result_o.is_number = 1'b1;
        result_o.saw_point = nxt.point;
        nxt.phase          = PhIdle;
      end
    end
  end

  assign state_o = nxt;

endmodule

`default_nettype wire

// File: rtl/radix_number_literal_parser.sv
// Top level of the radix-prefixed integer literal parser.
//
//   Channel    Dir  Handshake           Payload
//   in_i       in   valid/ready         ch[7:0], start_req
//   out_o      out  valid/ready         value[31:0], is_number, saw_point
//   cfg        in   cfg_we_i only       cfg_wdata_i[4:0] = default_radix
//
// A character transaction is registered, then processed by a single
// multiply-add (accumulator times base plus digit) into the accumulator, and
// a finished literal into the result register; one character per cycle
// unless a result waits; one that yields no result moves on even then.
// rst_ni clears the phase, base, accumulator and both valid flags at once.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module radix_number_literal_parser
  import rnlp_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [RadixBits-1:0] cfg_wdata_i,
  rnlp_in_if.sink                   in_i,
  rnlp_out_if.source                out_o
);

  logic                 item_valid;
  item_t                item;
  logic                 take;
  logic                 emit;
  logic                 out_free;
  logic                 load_out;
  logic [RadixBits-1:0] radix_q;
  state_t               state_q, state_d;
  result_t              result;
  result_t              out_q;
  logic                 out_valid_q, out_valid_d;

  // Input register.
  rnlp_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (take),
    .valid_o (item_valid),
    .item_o  (item)
  );

  // Per-character parse logic.
  rnlp_step u_step (
    .item_i          (item),
    .default_radix_i (radix_q),
    .state_i         (state_q),
    .state_o         (state_d),
    .emit_o          (emit),
    .result_o        (result)
  );

  // An item proceeds unless it would produce a result into a full slot.
  assign out_free = !out_valid_q || out_o.ready;
  assign take     = item_valid && (!emit || out_free);
  assign load_out = take && emit;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= BaseNone;
    end else if (cfg_we_i) begin
      radix_q <= cfg_wdata_i;
    end
  end

  // Parser state advances with every processed character.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PhIdle, base: BaseNone, acc: '0, point: 1'b0};
    end else if (take) begin
      state_q <= state_d;
    end
  end

  // Result register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= result;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.value     = out_q.value;
  assign out_o.is_number = out_q.is_number;
  assign out_o.saw_point = out_q.saw_point;

  // Checks on the parser's own logic.
  `ASSERT_IMPLIES(a_load_free, clk_i, rst_ni, load_out, out_free, "result slot overwritten")
  `ASSERT_NEXT(a_idle_after_emit, clk_i, rst_ni, load_out, state_q.phase == PhIdle, "phase not idle after result")
  `ASSERT_IMPLIES(a_nan_clean, clk_i, rst_ni, out_valid_q && !out_q.is_number, out_q.value == '0 && !out_q.saw_point, "not-a-number result carries data")
  `ASSERT_ALWAYS(a_base_range, clk_i, rst_ni, state_q.phase != PhDigits || (state_q.base != BaseNone && state_q.base <= BaseHex), "digit phase without a valid base")

endmodule

`default_nettype wire
